// ===== src/polar_sector_min_range_grid_defines.svh =====
// ----------------------------------------------------------------------------
// Polar sector min range grid: assertion macros
// Shared check forms; each expects clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef POLAR_SECTOR_MIN_RANGE_GRID_DEFINES_SVH
`define POLAR_SECTOR_MIN_RANGE_GRID_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSMRG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psmrg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PSMRG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psmrg: next-cycle check failed");

`endif

// ===== src/psmrg_pkg.sv =====
// ----------------------------------------------------------------------------
// psmrg_pkg
// Types and constants of the polar sector min range grid.
// ----------------------------------------------------------------------------
package psmrg_pkg;

   localparam int MAX_SECTORS_DEF = 64;
   localparam int CSR_DATA_W      = 21;
   localparam int CSR_INDEX_W     = 3;

   localparam logic [15:0] INF_RANGE = 16'hFFFF;
   localparam int          ANGLE_SAT = 25736;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECIP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = 3'd6;

   // register reset values
   localparam logic signed [15:0] ANGLE_LOW_RST  = -16'sd12868;
   localparam logic signed [15:0] ANGLE_HIGH_RST = 16'sd12868;
   localparam logic [15:0]        STEP_RST       = 16'd2860;
   localparam logic [20:0]        RECIP_RST      = 21'd367;
   localparam logic [6:0]         COUNT_RST      = 7'd9;
   localparam logic [15:0]        RANGE_LOW_RST  = 16'd0;
   localparam logic [15:0]        RANGE_HIGH_RST = 16'd6000;

   typedef enum logic [1:0] {
      ACT_UPDATE = 2'd0,
      ACT_QUERY  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

endpackage

// ===== src/polar_sector_min_range_grid.sv =====
// ----------------------------------------------------------------------------
// polar_sector_min_range_grid
// Table of angular sectors, each keeping the nearest range seen.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the item channel (valid/ready): an action, an angle, a range and
//   a sector index. rsp_* is the result channel (valid/ready): exactly one
//   result per item, in order. csr_* writes the limits, sector step,
//   reciprocal and count; write only while no item is in flight.
//   Each item passes through limit check and the angle-by-reciprocal
//   multiply, then index clamp and the sector RAM read, then min and write
//   back. The single RAM read/write path allows one item in flight: a new
//   item is taken in the same cycle the previous result is loaded, and not
//   before; rsp_valid rises once that result is loaded.
//   The result register parts the two sides: a new item is accepted while a
//   result waits; a stalled receiver holds the block only at the load step.
//   Reset (synchronous) restores the register defaults and marks every
//   sector as empty (reads 65535); clear does the same to the table at once,
//   so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "polar_sector_min_range_grid_defines.svh"

module polar_sector_min_range_grid #(
   parameter int MAX_SECTORS = psmrg_pkg::MAX_SECTORS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // item channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_action,
   input  logic signed [15:0]                   req_angle,
   input  logic [15:0]                          req_range_value,
   input  logic [5:0]                           req_sector_index,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid_res,
   output logic [5:0]                           rsp_sector_number,
   output logic [15:0]                          rsp_sector_value,
   output logic signed [15:0]                   rsp_sector_angle,
   // register write port
   input  logic                                 csr_we,
   input  logic [psmrg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [psmrg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import psmrg_pkg::*;

   localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTORS + 1);
   localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
   localparam int PW    = 16 + IDX_W;
   localparam int SW    = PW + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_INDEX,
      ST_MODIFY
   } state_type;

   // configuration registers
   logic signed [15:0] csr_angle_low_ff;
   logic signed [15:0] csr_angle_high_ff;
   logic [15:0]        csr_step_ff;
   logic [20:0]        csr_recip_ff;
   logic [6:0]         csr_count_ff;
   logic [15:0]        csr_range_low_ff;
   logic [15:0]        csr_range_high_ff;

   // sequencer and item registers
   state_type          state_ff;
   action_type         act_ff;
   logic signed [15:0] angle_ff;
   logic [15:0]        range_ff;
   logic [5:0]         si_ff;
   logic               ok_ff;
   logic               at_low_ff;
   logic               at_high_ff;
   logic [36:0]        prod_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [MAX_SECTORS-1:0] written_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_res_ff;
   logic [5:0]         rsp_sector_number_ff;
   logic [15:0]        rsp_sector_value_ff;
   logic signed [15:0] rsp_sector_angle_ff;

   // combinational values
   logic               take;
   logic               load_res;
   logic               wr_en;
   logic [CW-1:0]      count_ext;
   logic [CW-1:0]      used_count;
   logic [IDX_W-1:0]   cnt_m1;
   logic signed [16:0] diff;
   logic               angle_in_lim;
   logic               range_in_lim;
   logic               ok_in;
   logic [36:0]        prod_in;
   logic [16:0]        scaled;
   logic [IDX_W-1:0]   idx_in;
   logic [15:0]        ram_rdata;
   logic [15:0]        entry_val;
   logic [15:0]        upd_val;
   logic [PW-1:0]      start_prod;
   logic signed [SW-1:0] start_sum;
   logic signed [15:0] start_angle;
   logic               valid_res_in;
   logic [5:0]         number_in;
   logic [15:0]        value_in;
   logic signed [15:0] angle_res_in;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_angle_low_ff  <= ANGLE_LOW_RST;
         csr_angle_high_ff <= ANGLE_HIGH_RST;
         csr_step_ff       <= STEP_RST;
         csr_recip_ff      <= RECIP_RST;
         csr_count_ff      <= COUNT_RST;
         csr_range_low_ff  <= RANGE_LOW_RST;
         csr_range_high_ff <= RANGE_HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_LOW:  csr_angle_low_ff  <= signed'(csr_wdata[15:0]);
            CSR_ANGLE_HIGH: csr_angle_high_ff <= signed'(csr_wdata[15:0]);
            CSR_STEP:       csr_step_ff       <= csr_wdata[15:0];
            CSR_RECIP:      csr_recip_ff      <= csr_wdata[20:0];
            CSR_COUNT:      csr_count_ff      <= csr_wdata[6:0];
            CSR_RANGE_LOW:  csr_range_low_ff  <= csr_wdata[15:0];
            CSR_RANGE_HIGH: csr_range_high_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // effective sector count: zero acts as one, clamp to the table depth
   always_comb begin
      count_ext = CW'(csr_count_ff);
      if (csr_count_ff == 7'd0) begin
         used_count = CW'(1);
      end else if (count_ext > CW'(MAX_SECTORS)) begin
         used_count = CW'(MAX_SECTORS);
      end else begin
         used_count = count_ext;
      end
      cnt_m1 = IDX_W'(used_count - CW'(1));
   end

   // ---------------- handshake ----------------
   assign load_res  = (state_ff == ST_MODIFY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || load_res;
   assign take      = req_valid && req_ready;
   assign wr_en     = load_res && (act_ff == ACT_UPDATE) && ok_ff;

   // ---------------- limit check and scale ----------------
   always_comb begin
      diff         = {angle_ff[15], angle_ff} - {csr_angle_low_ff[15], csr_angle_low_ff};
      angle_in_lim = (angle_ff >= csr_angle_low_ff) && (angle_ff <= csr_angle_high_ff);
      range_in_lim = (range_ff >= csr_range_low_ff) && (range_ff <= csr_range_high_ff);
      prod_in      = 37'(diff[15:0]) * 37'(csr_recip_ff);
      case (act_ff)
         ACT_UPDATE: ok_in = angle_in_lim && range_in_lim;
         ACT_QUERY:  ok_in = angle_in_lim;
         ACT_READ:   ok_in = CW'(si_ff) < used_count;
         default:    ok_in = 1'b0;
      endcase
   end

   // ---------------- sector index ----------------
   always_comb begin
      scaled = prod_ff[36:20];
      if (act_ff == ACT_READ) begin
         idx_in = IDX_W'(si_ff);
      end else if (at_low_ff) begin
         idx_in = '0;
      end else if (at_high_ff || (scaled > 17'(cnt_m1))) begin
         idx_in = cnt_m1;
      end else begin
         idx_in = IDX_W'(scaled);
      end
   end

   psmrg_ram #(
      .WIDTH (16),
      .DEPTH (MAX_SECTORS)
   ) u_sector_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (upd_val),
      .rd_en   (state_ff == ST_INDEX),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   // ---------------- modify and result ----------------
   always_comb begin
      entry_val  = written_ff[idx_ff] ? ram_rdata : INF_RANGE;
      upd_val    = (range_ff < entry_val) ? range_ff : entry_val;
      start_prod = PW'(csr_step_ff) * PW'(idx_ff);
      start_sum  = SW'(csr_angle_low_ff) + signed'(SW'(start_prod));
      if (start_sum > SW'(ANGLE_SAT)) begin
         start_angle = 16'(ANGLE_SAT);
      end else if (start_sum < -SW'(ANGLE_SAT)) begin
         start_angle = -16'(ANGLE_SAT);
      end else begin
         start_angle = start_sum[15:0];
      end

      valid_res_in = ok_ff;
      number_in    = 6'(idx_ff);
      value_in     = entry_val;
      angle_res_in = start_angle;
      case (act_ff)
         ACT_UPDATE: begin
            value_in = upd_val;
            if (!ok_ff) begin
               number_in    = '0;
               value_in     = '0;
               angle_res_in = '0;
            end
         end
         ACT_QUERY: begin
            if (!ok_ff) begin
               number_in    = '0;
               value_in     = INF_RANGE;
               angle_res_in = '0;
            end
         end
         ACT_READ: begin
            if (!ok_ff) begin
               number_in    = si_ff;
               value_in     = INF_RANGE;
               angle_res_in = '0;
            end
         end
         default: begin
            valid_res_in = 1'b0;
            number_in    = '0;
            value_in     = INF_RANGE;
            angle_res_in = '0;
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         if (take) begin
            act_ff   <= action_type'(req_action);
            angle_ff <= req_angle;
            range_ff <= req_range_value;
            si_ff    <= req_sector_index;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               ok_ff      <= ok_in;
               at_low_ff  <= angle_ff == csr_angle_low_ff;
               at_high_ff <= angle_ff == csr_angle_high_ff;
               prod_ff    <= prod_in;
               state_ff   <= ST_INDEX;
            end
            ST_INDEX: begin
               idx_ff   <= idx_in;
               state_ff <= ST_MODIFY;
            end
            ST_MODIFY: begin
               if (load_res) begin
                  state_ff <= take ? ST_CALC : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // result register: load on completion, drop after transfer
         if (load_res) begin
            rsp_valid_ff         <= 1'b1;
            rsp_valid_res_ff     <= valid_res_in;
            rsp_sector_number_ff <= number_in;
            rsp_sector_value_ff  <= value_in;
            rsp_sector_angle_ff  <= angle_res_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (load_res && (act_ff == ACT_CLEAR)) begin
            written_ff <= '0;
         end else if (wr_en) begin
            written_ff[idx_ff] <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = rsp_valid_res_ff;
   assign rsp_sector_number = rsp_sector_number_ff;
   assign rsp_sector_value  = rsp_sector_value_ff;
   assign rsp_sector_angle  = rsp_sector_angle_ff;

   // ---------------- checks ----------------
   `PSMRG_ASSERT_NEXT(a_busy_after_take, take, !req_ready)
   `PSMRG_ASSERT_NEXT(a_clear_empties, load_res && (act_ff == ACT_CLEAR), written_ff == '0)
   `PSMRG_ASSERT_NEXT(a_write_marks, wr_en, written_ff[$past(idx_ff)])
   `PSMRG_ASSERT_NOW(a_miss_angle_zero, rsp_valid_ff && !rsp_valid_res_ff,
                     rsp_sector_angle_ff == '0)

endmodule

// ===== src/psmrg_ram.sv =====
// ----------------------------------------------------------------------------
// psmrg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psmrg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/polar_sector_min_range_grid_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_sector_min_range_grid_tb
// Self-checking bench for the polar sector nearest-range table.
// Sends updates, angle queries, index reads and clears under default, corner
// and random limit/sector settings. A shadow of the table and its registers
// predicts every reply, which is compared field by field in arrival order.
// Both channels idle at random; one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module polar_sector_min_range_grid_tb;
   import psmrg_pkg::*;

   localparam int          MAX_SECTORS     = MAX_SECTORS_DEF;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   localparam int unsigned MAX_ERR_PRINTS  = 10;

   typedef struct packed {
      logic signed [15:0] angle_low;
      logic signed [15:0] angle_high;
      logic [15:0]        step;
      logic [20:0]        recip;
      logic [6:0]         count;
      logic [15:0]        range_low;
      logic [15:0]        range_high;
   } grid_settings_type;

   typedef struct packed {
      logic               valid_res;
      logic [5:0]         sector_number;
      logic [15:0]        sector_value;
      logic signed [15:0] sector_angle;
   } sector_reply_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   action_type                   req_action = ACT_UPDATE;
   logic signed [15:0]           req_angle = '0;
   logic [15:0]                  req_range_value = '0;
   logic [5:0]                   req_sector_index = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_valid_res;
   logic [5:0]                   rsp_sector_number;
   logic [15:0]                  rsp_sector_value;
   logic signed [15:0]           rsp_sector_angle;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index = CSR_ANGLE_LOW;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // shadow of the table and its registers
   grid_settings_type            grid_cfg;
   logic [15:0]                  nearest_range [MAX_SECTORS];
   bit [MAX_SECTORS-1:0]         range_seen;

   sector_reply_type             replies_due [$];
   int unsigned                  bad_replies = 0;
   int unsigned                  quiet_cycles = 0;
   int unsigned                  hold_requests = 0;
   bit                           idle_on = 1'b1;

   polar_sector_min_range_grid i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_angle         (req_angle),
      .req_range_value   (req_range_value),
      .req_sector_index  (req_sector_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_sector_number (rsp_sector_number),
      .rsp_sector_value  (rsp_sector_value),
      .rsp_sector_angle  (rsp_sector_angle),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- shadow
   function automatic grid_settings_type make_settings(input int lo, input int hi,
         input int unsigned step, input int unsigned recip, input int unsigned count,
         input int unsigned rlo, input int unsigned rhi);
      grid_settings_type s;
      s.angle_low  = 16'(lo);
      s.angle_high = 16'(hi);
      s.step       = 16'(step);
      s.recip      = 21'(recip);
      s.count      = 7'(count);
      s.range_low  = 16'(rlo);
      s.range_high = 16'(rhi);
      return s;
   endfunction

   function automatic int unsigned used_sectors();
      if (grid_cfg.count == 0) return 1;
      if (grid_cfg.count > MAX_SECTORS) return MAX_SECTORS;
      return grid_cfg.count;
   endfunction

   function automatic logic [15:0] stored_range(input int unsigned n);
      return range_seen[n] ? nearest_range[n] : INF_RANGE;
   endfunction

   // map an angle to its sector; 0 when outside the angle limits
   function automatic bit locate_sector(input logic signed [15:0] ang, output int unsigned n);
      int                lo, hi, a;
      int unsigned       cnt;
      longint unsigned   prod;
      lo  = $signed(grid_cfg.angle_low);
      hi  = $signed(grid_cfg.angle_high);
      a   = ang;
      cnt = used_sectors();
      n   = 0;
      if (a < lo || a > hi) return 1'b0;
      if (a == lo) n = 0;
      else if (a == hi) n = cnt - 1;
      else begin
         // reciprocal multiply stands in for the division by the step
         prod = longint'(a - lo) * grid_cfg.recip;
         prod = prod >> 20;
         if (prod > cnt - 1) prod = cnt - 1;
         n = int'(prod);
      end
      return 1'b1;
   endfunction

   function automatic logic signed [15:0] sector_start(input int unsigned n);
      longint s;
      s = longint'($signed(grid_cfg.angle_low)) + longint'(grid_cfg.step) * longint'(n);
      if (s > ANGLE_SAT) s = ANGLE_SAT;
      if (s < -ANGLE_SAT) s = -ANGLE_SAT;
      return 16'(s);
   endfunction

   // advance the shadow table by one action and return the reply it gives
   function automatic sector_reply_type apply_action(input action_type act,
         input logic signed [15:0] ang, input logic [15:0] rng, input logic [5:0] idx);
      sector_reply_type r;
      int unsigned      n;
      logic [15:0]      v;
      r.valid_res     = 1'b0;
      r.sector_number = '0;
      r.sector_value  = INF_RANGE;
      r.sector_angle  = '0;
      case (act)
         ACT_UPDATE: begin
            r.sector_value = '0;
            if (rng >= grid_cfg.range_low && rng <= grid_cfg.range_high
                && locate_sector(ang, n)) begin
               v = stored_range(n);
               if (rng < v) v = rng;
               nearest_range[n] = v;
               range_seen[n]    = 1'b1;
               r = '{1'b1, 6'(n), v, sector_start(n)};
            end
         end
         ACT_QUERY: begin
            if (locate_sector(ang, n))
               r = '{1'b1, 6'(n), stored_range(n), sector_start(n)};
         end
         ACT_CLEAR: begin
            range_seen = '0;
         end
         default: begin
            r.sector_number = idx;
            if (idx < used_sectors())
               r = '{1'b1, idx, stored_range(idx), sector_start(idx)};
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   function automatic int unsigned idle_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one item, hold it until the transfer, then record its reply
   task automatic send_item(input action_type act, input int ang, input int unsigned rng,
         input int unsigned idx);
      int unsigned gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_angle        <= 16'(ang);
      req_range_value  <= 16'(rng);
      req_sector_index <= 6'(idx);
      do @(posedge clock); while (!req_ready);
      replies_due.push_back(apply_action(act, 16'(ang), 16'(rng), 6'(idx)));
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   // write every register in turn; call only with the block idle
   task automatic write_settings(input grid_settings_type s);
      csr_we    <= 1'b1;
      csr_index <= CSR_ANGLE_LOW;
      csr_wdata <= {5'd0, s.angle_low};
      @(posedge clock);
      csr_index <= CSR_ANGLE_HIGH;
      csr_wdata <= {5'd0, s.angle_high};
      @(posedge clock);
      csr_index <= CSR_STEP;
      csr_wdata <= CSR_DATA_W'(s.step);
      @(posedge clock);
      csr_index <= CSR_RECIP;
      csr_wdata <= s.recip;
      @(posedge clock);
      csr_index <= CSR_COUNT;
      csr_wdata <= CSR_DATA_W'(s.count);
      @(posedge clock);
      csr_index <= CSR_RANGE_LOW;
      csr_wdata <= CSR_DATA_W'(s.range_low);
      @(posedge clock);
      csr_index <= CSR_RANGE_HIGH;
      csr_wdata <= CSR_DATA_W'(s.range_high);
      @(posedge clock);
      csr_we   <= 1'b0;
      grid_cfg  = s;
   endtask

   // mostly in-limit beams with random content, some edge and stray values
   task automatic send_random_items(input int unsigned count);
      int          lo, hi, rlo, rhi, ang, rng;
      int unsigned pick, idx;
      action_type  act;
      lo  = $signed(grid_cfg.angle_low);
      hi  = $signed(grid_cfg.angle_high);
      rlo = grid_cfg.range_low;
      rhi = grid_cfg.range_high;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 78 && lo <= hi) ang = lo + int'($urandom_range(0, hi - lo));
         else if (pick < 84) ang = lo;
         else if (pick < 90) ang = hi;
         else if (pick < 94) ang = pick[0] ? lo - 1 : hi + 1;
         else ang = int'($urandom_range(0, 2 * ANGLE_SAT)) - ANGLE_SAT;
         if (ang < -ANGLE_SAT) ang = -ANGLE_SAT;
         if (ang > ANGLE_SAT) ang = ANGLE_SAT;

         pick = $urandom_range(0, 99);
         if (pick < 80 && rlo <= rhi) rng = rlo + int'($urandom_range(0, rhi - rlo));
         else if (pick < 85) rng = rlo;
         else if (pick < 90) rng = rhi;
         else if (pick < 94) rng = pick[0] ? rlo - 1 : rhi + 1;
         else rng = int'($urandom_range(0, 65534));
         if (rng < 0) rng = 0;
         if (rng > 65534) rng = 65534;

         if ($urandom_range(0, 99) < 70) idx = $urandom_range(0, used_sectors() - 1);
         else idx = $urandom_range(0, MAX_SECTORS - 1);

         pick = $urandom_range(0, 99);
         if (pick < 48) act = ACT_UPDATE;
         else if (pick < 72) act = ACT_QUERY;
         else if (pick < 97) act = ACT_READ;
         else act = ACT_CLEAR;

         send_item(act, ang, rng, idx);
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed_defaults();
      send_item(ACT_QUERY, 0, 0, 0);                          // empty sector reads infinity
      send_item(ACT_UPDATE, ANGLE_LOW_RST, 500, 0);           // low limit lands in sector 0
      send_item(ACT_UPDATE, ANGLE_HIGH_RST, RANGE_HIGH_RST, 0);
      send_item(ACT_UPDATE, ANGLE_HIGH_RST - 1, RANGE_LOW_RST, 0); // index past end: clamp
      send_item(ACT_UPDATE, 0, 3000, 0);
      send_item(ACT_UPDATE, 0, 4000, 0);                      // keep the smaller range
      send_item(ACT_UPDATE, 0, RANGE_HIGH_RST + 1, 0);        // refused: range
      send_item(ACT_UPDATE, ANGLE_LOW_RST - 1, 100, 0);       // refused: angle
      send_item(ACT_UPDATE, ANGLE_SAT, 100, 0);
      send_item(ACT_UPDATE, -ANGLE_SAT, 65534, MAX_SECTORS - 1);
      send_item(ACT_QUERY, -ANGLE_SAT, 0, 0);                 // out of limits
      send_item(ACT_QUERY, ANGLE_SAT, 65534, MAX_SECTORS - 1);
      send_item(ACT_QUERY, ANGLE_HIGH_RST, 0, 0);
      send_item(ACT_READ, 0, 0, 0);
      send_item(ACT_READ, 0, 0, COUNT_RST - 1);
      send_item(ACT_READ, 0, 0, COUNT_RST);                   // sector not in use
      send_item(ACT_READ, -ANGLE_SAT, 65534, MAX_SECTORS - 1);
      send_item(ACT_READ, 0, 0, 4);
      send_item(ACT_CLEAR, ANGLE_SAT, 65534, MAX_SECTORS - 1);
      send_item(ACT_READ, 0, 0, 4);
      send_item(ACT_QUERY, 0, 0, 0);
      send_item(ACT_UPDATE, -1, 1, 0);
      drain_replies();
   endtask

   task automatic test_extreme_settings();
      grid_settings_type corner [5];
      corner[0] = make_settings(-ANGLE_SAT, ANGLE_SAT, 1, 1 << 20, MAX_SECTORS, 0, 65534);
      corner[1] = make_settings(-ANGLE_SAT, ANGLE_SAT, 2 * ANGLE_SAT, 20, 1, 65534, 65534);
      // zero count acts as a single sector
      corner[2] = make_settings(-100, 100, 200, 5243, 0, 0, 0);
      // count above the table size acts as the full table
      corner[3] = make_settings(ANGLE_SAT, ANGLE_SAT, 804, 1304, 127, 100, 200);
      // crossed limits accept no angle
      corner[4] = make_settings(1000, -1000, 100, 10486, MAX_SECTORS, 0, 6000);
      foreach (corner[k]) begin
         write_settings(corner[k]);
         send_random_items(40);
         drain_replies();
      end
   endtask

   task automatic test_random_settings();
      int          a, b, lo, hi, rlo, rhi;
      int unsigned cnt, step, recip;
      repeat (6) begin
         a = int'($urandom_range(0, 2 * ANGLE_SAT)) - ANGLE_SAT;
         b = int'($urandom_range(0, 2 * ANGLE_SAT)) - ANGLE_SAT;
         if ($urandom_range(0, 9) == 0) begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
         end else begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end
         cnt = $urandom_range(1, MAX_SECTORS);
         if (hi > lo && $urandom_range(0, 4) != 0) step = (hi - lo) / cnt;
         else step = $urandom_range(1, 2 * ANGLE_SAT);
         if (step == 0) step = 1;
         recip = ((1 << 20) + step / 2) / step;
         if (recip < 20) recip = 20;
         if ($urandom_range(0, 9) == 0) recip = $urandom_range(20, 1 << 20);
         rlo = $urandom_range(0, 3000);
         rhi = rlo + int'($urandom_range(0, 65534 - rlo));
         write_settings(make_settings(lo, hi, step, recip, cnt, rlo, rhi));
         send_random_items(115);
         drain_replies();
      end
   endtask

   // receiver holds off while items keep coming, then the sender waits it out
   task automatic test_receiver_hold();
      idle_on = 1'b0;
      hold_requests++;
      send_random_items(60);
      drain_replies();
      idle_on = 1'b1;
   endtask

   task automatic test_streaming();
      idle_on = 1'b0;
      send_random_items(150);
      drain_replies();
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking
   function automatic void log_error(input string msg);
      bad_replies++;
      if (bad_replies <= MAX_ERR_PRINTS) $display("%0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin : check_replies
      sector_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            log_error($sformatf("reply with none pending: valid=%0b sector=%0d value=%0d angle=%0d",
               rsp_valid_res, rsp_sector_number, rsp_sector_value, rsp_sector_angle));
         end else begin
            want = replies_due.pop_front();
            if (want.valid_res !== rsp_valid_res || want.sector_number !== rsp_sector_number
                || want.sector_value !== rsp_sector_value
                || want.sector_angle !== rsp_sector_angle) begin
               log_error($sformatf({"reply mismatch: expected valid=%0b sector=%0d value=%0d ",
                  "angle=%0d, got valid=%0b sector=%0d value=%0d angle=%0d"},
                  want.valid_res, want.sector_number, want.sector_value,
                  $signed(want.sector_angle), rsp_valid_res, rsp_sector_number,
                  rsp_sector_value, rsp_sector_angle));
            end
         end
      end
   end

   initial begin : drive_rsp_ready
      int unsigned gap;
      int unsigned holds_done;
      holds_done = 0;
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = idle_gap();
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // count cycles without a transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      grid_cfg = make_settings(ANGLE_LOW_RST, ANGLE_HIGH_RST, STEP_RST, RECIP_RST, COUNT_RST,
                               RANGE_LOW_RST, RANGE_HIGH_RST);
      range_seen = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_extreme_settings();
      test_random_settings();
      test_receiver_hold();
      test_streaming();
      drain_replies();
      repeat (8) @(posedge clock);
      if (bad_replies == 0 && replies_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
